// ===== hw/rtl/lbpv_pkg.sv =====
// Package for the LBP variant code engine: sizes, register indexes,
// mode codes and the result word type. No dependencies.
package lbpv_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int POS_W      = 10;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int LINES      = 4;
    localparam int SLOT_W     = $clog2(LINES);
    localparam int QDEPTH     = 3;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        MODE_LBP8        = 3'd0,
        MODE_CSLBP       = 3'd1,
        MODE_DIAMOND     = 3'd2,
        MODE_SQUARE      = 3'd3,
        MODE_RING        = 3'd4,
        MODE_HALF_RING   = 3'd5,
        MODE_THREE_PATCH = 3'd6,
        MODE_FOUR_PATCH  = 3'd7
    } t_mode;

    typedef logic [LINES-1:0][PIX_W-1:0] t_line_word;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  center_row;
        logic [POS_W-1:0]  center_col;
        logic              frame_end;
    } t_code_word;

    typedef struct packed {
        logic              emit;
        logic [SLOT_W-1:0] slot;
        logic [COL_W-1:0]  x;
        logic [POS_W-1:0]  crow;
        logic [POS_W-1:0]  ccol;
        logic              fend;
        t_mode             mode;
        logic [PIX_W-1:0]  pix;
    } t_stage;

endpackage

// ===== hw/rtl/lbpv_pix_if.sv =====
// Pixel channel: valid/ready handshake carrying one pixel word.
// Depends on lbpv_pkg.
interface lbpv_pix_if;
    logic                       valid;
    logic                       ready;
    logic [lbpv_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== hw/rtl/lbpv_code_if.sv =====
// Code channel: valid/ready handshake carrying one code word with position.
// Depends on lbpv_pkg.
interface lbpv_code_if;
    logic                        valid;
    logic                        ready;
    logic [lbpv_pkg::CODE_W-1:0] code;
    logic [lbpv_pkg::POS_W-1:0]  center_row;
    logic [lbpv_pkg::POS_W-1:0]  center_col;
    logic                        frame_end;

    modport source (output valid, output code, output center_row, output center_col,
                    output frame_end, input ready);
    modport sink   (input valid, input code, input center_row, input center_col,
                    input frame_end, output ready);
endinterface

// ===== hw/rtl/lbp_variant_code_engine_core.sv =====
// Top level of the LBP variant code engine: line-store memory, 5x5 window,
// code logic and output queue. Depends on lbpv_pkg, lbpv_pix_if, lbpv_code_if.
//
// Usage:
//   i_pix carries grayscale pixels in raster order; one word is taken per
//   clock while i_pix.ready is high. o_code carries one code word per interior
//   centre pixel (margin 1 for modes 0..5, 2 for modes 6 and 7), with its row,
//   column and a frame_end flag on the last code of the frame.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 mode, 1 frame width, 2 frame height); a size write restarts the frame.
//   Write only while the block is idle.
//   Output path: the pixel that completes its window is registered in stage
//   1, then its code word is written into the output queue, raising o_code.valid.
//   Throughput: one pixel per clock while i_pix.ready is high, set by the single
//   read-modify-write per pixel on the line store (one word per column, four rows).
//   Reset: positions clear, mode 0, 1024 x 1024 frame, output queue empty.
//   The line store needs no clearing.
//   Stall: a three-word output queue absorbs results; i_pix.ready drops only
//   when the queue and the stage in flight could fill it, and returns as soon
//   as the receiver takes words again.
module lbp_variant_code_engine_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lbpv_pix_if.sink                       i_pix,
    lbpv_code_if.source                    o_code,
    input  logic                           i_cfg_we,
    input  logic [lbpv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lbpv_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W  = lbpv_pkg::COL_W;
    localparam int ROW_W  = lbpv_pkg::ROW_W;
    localparam int PIX_W  = lbpv_pkg::PIX_W;
    localparam int POS_W  = lbpv_pkg::POS_W;
    localparam int SLOT_W = lbpv_pkg::SLOT_W;
    localparam int LINES  = lbpv_pkg::LINES;
    localparam int QDEPTH = lbpv_pkg::QDEPTH;
    localparam int QPTR_W = lbpv_pkg::QPTR_W;
    localparam int QCNT_W = lbpv_pkg::QCNT_W;

    function automatic logic gt_diff(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d);
        logic signed [PIX_W:0] dab;
        logic signed [PIX_W:0] dcd;
        dab = $signed({1'b0, a}) - $signed({1'b0, b});
        dcd = $signed({1'b0, c}) - $signed({1'b0, d});
        return dab > dcd;
    endfunction

    // configuration and position
    lbpv_pkg::t_mode   r_mode;
    logic [COL_W-1:0]  r_w_last;
    logic [ROW_W-1:0]  r_h_last;
    logic [COL_W-1:0]  r_x;
    logic [ROW_W-1:0]  r_y;
    logic [COL_W-1:0]  cfg_w_last;
    logic [ROW_W-1:0]  cfg_h_last;
    logic              accept;
    logic              patch;
    logic              emit;
    lbpv_pkg::t_stage  n_s1;

    // stage 1
    logic              r_s1_valid;
    lbpv_pkg::t_stage  r_s1;

    // line store
    lbpv_pkg::t_line_word mem [lbpv_pkg::MAX_WIDTH];
    lbpv_pkg::t_line_word r_rdata;
    lbpv_pkg::t_line_word r_fwd_word;
    logic                 r_fwd;
    lbpv_pkg::t_line_word rd_word;
    lbpv_pkg::t_line_word wr_word;

    // window
    logic [4:0][4:0][PIX_W-1:0] r_win;
    logic [4:0][4:0][PIX_W-1:0] n_win;
    logic [lbpv_pkg::CODE_W-1:0] code;

    // output queue
    lbpv_pkg::t_code_word r_q [QDEPTH];
    logic [QPTR_W-1:0]    r_wp;
    logic [QPTR_W-1:0]    r_rp;
    logic [QCNT_W-1:0]    r_cnt;
    logic [QCNT_W:0]      occ;
    logic                 push;
    logic                 pop;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_w_last = '0;
        end else if (32'(i_cfg_data) > 32'(lbpv_pkg::MAX_WIDTH)) begin
            cfg_w_last = COL_W'(lbpv_pkg::MAX_WIDTH - 1);
        end else begin
            cfg_w_last = COL_W'(32'(i_cfg_data) - 32'd1);
        end
        if (i_cfg_data == '0) begin
            cfg_h_last = '0;
        end else if (32'(i_cfg_data) > 32'(lbpv_pkg::MAX_HEIGHT)) begin
            cfg_h_last = ROW_W'(lbpv_pkg::MAX_HEIGHT - 1);
        end else begin
            cfg_h_last = ROW_W'(32'(i_cfg_data) - 32'd1);
        end
    end

    assign accept = i_pix.valid && i_pix.ready;
    assign patch  = r_mode inside {lbpv_pkg::MODE_THREE_PATCH, lbpv_pkg::MODE_FOUR_PATCH};
    assign emit   = patch ? (r_y >= ROW_W'(4) && r_x >= COL_W'(4))
                          : (r_y >= ROW_W'(2) && r_x >= COL_W'(2));

    always_comb begin
        n_s1.emit = emit;
        n_s1.slot = r_y[SLOT_W-1:0];
        n_s1.x    = r_x;
        n_s1.crow = POS_W'(patch ? r_y - ROW_W'(2) : r_y - ROW_W'(1));
        n_s1.ccol = POS_W'(patch ? r_x - COL_W'(2) : r_x - COL_W'(1));
        n_s1.fend = (r_y == r_h_last) && (r_x == r_w_last);
        n_s1.mode = r_mode;
        n_s1.pix  = i_pix.pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= lbpv_pkg::MODE_LBP8;
            r_w_last <= COL_W'(lbpv_pkg::MAX_WIDTH - 1);
            r_h_last <= ROW_W'(lbpv_pkg::MAX_HEIGHT - 1);
            r_x      <= '0;
            r_y      <= '0;
        end else if (i_cfg_we) begin
            case (lbpv_pkg::t_reg_idx'(i_cfg_idx))
                lbpv_pkg::REG_MODE: begin
                    r_mode <= lbpv_pkg::t_mode'(i_cfg_data[2:0]);
                end
                lbpv_pkg::REG_WIDTH: begin
                    r_w_last <= cfg_w_last;
                    r_x      <= '0;
                    r_y      <= '0;
                end
                lbpv_pkg::REG_HEIGHT: begin
                    r_h_last <= cfg_h_last;
                    r_x      <= '0;
                    r_y      <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (r_x == r_w_last) begin
                r_x <= '0;
                r_y <= (r_y == r_h_last) ? '0 : r_y + ROW_W'(1);
            end else begin
                r_x <= r_x + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_fwd      <= accept && r_s1_valid && (r_x == r_s1.x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        r_fwd_word <= wr_word;
    end

    // read-first memory; a write to the entry being read is forwarded
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem[r_s1.x] <= wr_word;
        end
        if (accept) begin
            r_rdata <= mem[r_x];
        end
    end

    always_comb begin
        rd_word = r_fwd ? r_fwd_word : r_rdata;
        wr_word = rd_word;
        wr_word[r_s1.slot] = r_s1.pix;
    end

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_win[i][j] = r_win[i][j+1];
            end
        end
        for (int i = 0; i < LINES; i++) begin
            n_win[i][4] = rd_word[SLOT_W'(r_s1.slot + SLOT_W'(i))];
        end
        n_win[4][4] = r_s1.pix;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        code = '0;
        case (r_s1.mode)
            lbpv_pkg::MODE_LBP8: begin
                code[0] = n_win[2][3] > n_win[3][3];
                code[1] = n_win[2][4] > n_win[3][3];
                code[2] = n_win[3][4] > n_win[3][3];
                code[3] = n_win[4][4] > n_win[3][3];
                code[4] = n_win[4][3] > n_win[3][3];
                code[5] = n_win[4][2] > n_win[3][3];
                code[6] = n_win[3][2] > n_win[3][3];
                code[7] = n_win[2][2] > n_win[3][3];
            end
            lbpv_pkg::MODE_CSLBP: begin
                code[0] = n_win[2][3] > n_win[4][3];
                code[1] = n_win[2][4] > n_win[4][2];
                code[2] = n_win[3][4] > n_win[3][2];
                code[3] = n_win[4][4] > n_win[2][2];
            end
            lbpv_pkg::MODE_DIAMOND: begin
                code[0] = n_win[2][3] > n_win[3][4];
                code[1] = n_win[3][4] > n_win[4][3];
                code[2] = n_win[4][3] > n_win[3][2];
                code[3] = n_win[3][2] > n_win[2][3];
            end
            lbpv_pkg::MODE_SQUARE: begin
                code[0] = n_win[2][2] > n_win[2][4];
                code[1] = n_win[2][4] > n_win[4][4];
                code[2] = n_win[4][4] > n_win[4][2];
                code[3] = n_win[4][2] > n_win[2][2];
            end
            lbpv_pkg::MODE_RING: begin
                code[0] = n_win[2][3] > n_win[2][2];
                code[1] = n_win[2][4] > n_win[2][3];
                code[2] = n_win[3][4] > n_win[2][4];
                code[3] = n_win[4][4] > n_win[3][4];
                code[4] = n_win[4][3] > n_win[4][4];
                code[5] = n_win[4][2] > n_win[4][3];
                code[6] = n_win[3][2] > n_win[4][2];
                code[7] = n_win[2][2] > n_win[3][2];
            end
            lbpv_pkg::MODE_HALF_RING: begin
                code[0] = n_win[2][3] > n_win[3][3];
                code[1] = n_win[2][4] > n_win[3][3];
                code[2] = n_win[3][4] > n_win[3][3];
                code[3] = n_win[4][4] > n_win[3][3];
            end
            lbpv_pkg::MODE_THREE_PATCH: begin
                code[0] = gt_diff(n_win[2][2], n_win[2][0], n_win[2][2], n_win[0][2]);
                code[1] = gt_diff(n_win[2][2], n_win[1][1], n_win[2][2], n_win[1][3]);
                code[2] = gt_diff(n_win[2][2], n_win[0][2], n_win[2][2], n_win[2][4]);
                code[3] = gt_diff(n_win[2][2], n_win[1][3], n_win[2][2], n_win[3][3]);
                code[4] = gt_diff(n_win[2][2], n_win[2][4], n_win[2][2], n_win[3][2]);
                code[5] = gt_diff(n_win[2][2], n_win[3][3], n_win[2][2], n_win[3][1]);
                code[6] = gt_diff(n_win[2][2], n_win[3][2], n_win[2][2], n_win[2][0]);
                code[7] = gt_diff(n_win[2][2], n_win[3][1], n_win[2][2], n_win[1][1]);
            end
            lbpv_pkg::MODE_FOUR_PATCH: begin
                code[0] = gt_diff(n_win[2][3], n_win[4][4], n_win[2][1], n_win[0][0]);
                code[1] = gt_diff(n_win[3][3], n_win[4][2], n_win[1][1], n_win[0][2]);
                code[2] = gt_diff(n_win[3][2], n_win[4][0], n_win[1][2], n_win[0][4]);
                code[3] = gt_diff(n_win[3][1], n_win[2][0], n_win[1][3], n_win[2][4]);
            end
            default: begin
                code = '0;
            end
        endcase
    end

    // output queue
    assign push = r_s1_valid && r_s1.emit;
    assign pop  = o_code.valid && o_code.ready;
    assign occ  = {1'b0, r_cnt} + {{QCNT_W{1'b0}}, push};

    assign i_pix.ready = occ < (QCNT_W+1)'(QDEPTH);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{code: code, center_row: r_s1.crow, center_col: r_s1.ccol,
                           frame_end: r_s1.fend};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_code.valid      = r_cnt != '0;
    assign o_code.code       = r_q[r_rp].code;
    assign o_code.center_row = r_q[r_rp].center_row;
    assign o_code.center_col = r_q[r_rp].center_col;
    assign o_code.frame_end  = r_q[r_rp].frame_end;

    // checks
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == QCNT_W'(QDEPTH)) |-> (!push || pop))
        else $error("output queue overflow");

    a_fwd_has_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forward without a word in stage 1");

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cfg_we && r_x == r_w_last) |=> (r_x == '0))
        else $error("column did not wrap at row end");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_x <= r_w_last) && (r_y <= r_h_last))
        else $error("position outside the frame");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for lbp_variant_code_engine_core: streams raster pixels under all eight code modes
// and many frame sizes, checks each code word against an in-bench texture predictor.
// Depends on lbpv_pkg, lbpv_pix_if, lbpv_code_if and the core.
module tb;

    localparam int PIX_W      = lbpv_pkg::PIX_W;
    localparam int CODE_W     = lbpv_pkg::CODE_W;
    localparam int POS_W      = lbpv_pkg::POS_W;
    localparam int CFG_W      = lbpv_pkg::CFG_W;
    localparam int CFG_IDX_W  = lbpv_pkg::CFG_IDX_W;
    localparam int LINES      = lbpv_pkg::LINES;
    localparam int MAX_WIDTH  = lbpv_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = lbpv_pkg::MAX_HEIGHT;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int RAND_PIXELS   = 1000;
    localparam int TALL_PIXELS   = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRINT_CAP     = 40;

    typedef enum bit {ROW_PIXEL, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        logic [PIX_W-1:0]     pix;
        bit                   typed;
        lbpv_pkg::t_code_word word;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    lbpv_pix_if  pix_ch ();
    lbpv_code_if code_ch ();

    lbp_variant_code_engine_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_code     (code_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    bit   [PIX_W-1:0] ls_mem [LINES*MAX_WIDTH];
    bit   [PIX_W-1:0] win [5][5];
    int unsigned      cur_row = 0;
    int unsigned      cur_col = 0;
    lbpv_pkg::t_mode  cur_mode = lbpv_pkg::MODE_LBP8;
    logic [CFG_W-1:0] cur_w = CFG_W'(1024);
    logic [CFG_W-1:0] cur_h = CFG_W'(1024);

    lbpv_pkg::t_code_word pending_codes [$];
    t_dir_row             dir_tab [$];
    int         src_idle_pct = 0;
    int         snk_stall_pct = 0;
    int         stall_hold = 0;
    int         pixels_sent = 0;
    int         codes_seen = 0;
    int         mismatches = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return 32'(v);
    endfunction

    function automatic logic [PIX_W-1:0] near(input int dr, input int dc);
        return win[3+dr][3+dc];
    endfunction

    function automatic logic [PIX_W-1:0] wide(input int dr, input int dc);
        return win[2+dr][2+dc];
    endfunction

    function automatic logic signed [PIX_W:0] sd(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic logic [CODE_W-1:0] texture_code(input lbpv_pkg::t_mode md);
        logic [CODE_W-1:0] v;
        logic [PIX_W-1:0]  cen;
        logic [PIX_W-1:0]  c0;
        v   = '0;
        cen = near(0, 0);
        c0  = wide(0, 0);
        case (md)
            lbpv_pkg::MODE_LBP8, lbpv_pkg::MODE_HALF_RING: begin
                v[0] = near(-1, 0) > cen;
                v[1] = near(-1, 1) > cen;
                v[2] = near(0, 1) > cen;
                v[3] = near(1, 1) > cen;
                if (md == lbpv_pkg::MODE_LBP8) begin
                    v[4] = near(1, 0) > cen;
                    v[5] = near(1, -1) > cen;
                    v[6] = near(0, -1) > cen;
                    v[7] = near(-1, -1) > cen;
                end
            end
            lbpv_pkg::MODE_CSLBP: begin
                v[0] = near(-1, 0) > near(1, 0);
                v[1] = near(-1, 1) > near(1, -1);
                v[2] = near(0, 1) > near(0, -1);
                v[3] = near(1, 1) > near(-1, -1);
            end
            lbpv_pkg::MODE_DIAMOND: begin
                v[0] = near(-1, 0) > near(0, 1);
                v[1] = near(0, 1) > near(1, 0);
                v[2] = near(1, 0) > near(0, -1);
                v[3] = near(0, -1) > near(-1, 0);
            end
            lbpv_pkg::MODE_SQUARE: begin
                v[0] = near(-1, -1) > near(-1, 1);
                v[1] = near(-1, 1) > near(1, 1);
                v[2] = near(1, 1) > near(1, -1);
                v[3] = near(1, -1) > near(-1, -1);
            end
            lbpv_pkg::MODE_RING: begin
                v[0] = near(-1, 0) > near(-1, -1);
                v[1] = near(-1, 1) > near(-1, 0);
                v[2] = near(0, 1) > near(-1, 1);
                v[3] = near(1, 1) > near(0, 1);
                v[4] = near(1, 0) > near(1, 1);
                v[5] = near(1, -1) > near(1, 0);
                v[6] = near(0, -1) > near(1, -1);
                v[7] = near(-1, -1) > near(0, -1);
            end
            lbpv_pkg::MODE_THREE_PATCH: begin
                v[0] = sd(c0, wide(0, -2)) > sd(c0, wide(-2, 0));
                v[1] = sd(c0, wide(-1, -1)) > sd(c0, wide(-1, 1));
                v[2] = sd(c0, wide(-2, 0)) > sd(c0, wide(0, 2));
                v[3] = sd(c0, wide(-1, 1)) > sd(c0, wide(1, 1));
                v[4] = sd(c0, wide(0, 2)) > sd(c0, wide(1, 0));
                v[5] = sd(c0, wide(1, 1)) > sd(c0, wide(1, -1));
                v[6] = sd(c0, wide(1, 0)) > sd(c0, wide(0, -2));
                v[7] = sd(c0, wide(1, -1)) > sd(c0, wide(-1, -1));
            end
            default: begin
                v[0] = sd(wide(0, 1), wide(2, 2)) > sd(wide(0, -1), wide(-2, -2));
                v[1] = sd(wide(1, 1), wide(2, 0)) > sd(wide(-1, -1), wide(-2, 0));
                v[2] = sd(wide(1, 0), wide(2, -2)) > sd(wide(-1, 0), wide(-2, 2));
                v[3] = sd(wide(1, -1), wide(0, -2)) > sd(wide(-1, 1), wide(0, 2));
            end
        endcase
        return v;
    endfunction

    // advance the window by one pixel; returns 1 when a code word is due
    function automatic bit slide_window(input logic [PIX_W-1:0] p,
                                        output lbpv_pkg::t_code_word cw);
        int unsigned w;
        int unsigned h;
        int unsigned y;
        int unsigned x;
        int unsigned m;
        int          r;
        int          c;
        bit          due;
        w = clamp_dim(cur_w, MAX_WIDTH);
        h = clamp_dim(cur_h, MAX_HEIGHT);
        y = cur_row;
        x = cur_col;
        m = (cur_mode >= lbpv_pkg::MODE_THREE_PATCH) ? 2 : 1;
        if (x >= w) x = w - 1;
        if (y >= h) y = h - 1;
        for (r = 0; r < 5; r++)
            for (c = 0; c < 4; c++)
                win[r][c] = win[r][c+1];
        for (r = 0; r < LINES; r++)
            win[r][4] = ls_mem[((y + r) % LINES) * MAX_WIDTH + x];
        win[4][4] = p;
        ls_mem[(y % LINES) * MAX_WIDTH + x] = p;
        cw  = '0;
        due = 1'b0;
        if (y >= 2 * m && x >= 2 * m) begin
            cw.code       = texture_code(cur_mode);
            cw.center_row = POS_W'(y - m);
            cw.center_col = POS_W'(x - m);
            cw.frame_end  = (y == h - 1) && (x == w - 1);
            due = 1'b1;
        end
        if (x + 1 >= w) begin
            cur_col = 0;
            cur_row = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            cur_col = x + 1;
            cur_row = y;
        end
        return due;
    endfunction

    function automatic t_dir_row px_row(input logic [PIX_W-1:0] p, input bit typed = 1'b0,
                                        input lbpv_pkg::t_code_word word = '0);
        t_dir_row row;
        row       = '0;
        row.kind  = ROW_PIXEL;
        row.pix   = p;
        row.typed = typed;
        row.word  = word;
        return row;
    endfunction

    function automatic t_dir_row wr_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
        t_dir_row row;
        row      = '0;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.val  = val;
        return row;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel(input logic [PIX_W-1:0] base);
        case ($urandom_range(3))
            0, 1:    return PIX_W'($urandom_range(255));
            2:       return PIX_W'(base + $urandom_range(3));
            default: return $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    task automatic drain_codes();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_codes.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain_codes();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lbpv_pkg::REG_MODE: cur_mode = lbpv_pkg::t_mode'(val[2:0]);
            lbpv_pkg::REG_WIDTH: begin
                cur_w   = val;
                cur_row = 0;
                cur_col = 0;
            end
            lbpv_pkg::REG_HEIGHT: begin
                cur_h   = val;
                cur_row = 0;
                cur_col = 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] p, input bit typed,
                              input lbpv_pkg::t_code_word word);
        lbpv_pkg::t_code_word predicted;
        bit                   got;
        while ($urandom_range(99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= p;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        pixels_sent++;
        got = slide_window(p, predicted);
        if (typed) pending_codes = {pending_codes, word};
        else if (got) pending_codes = {pending_codes, predicted};
    endtask

    task automatic stream_pixels(input int n, input logic [PIX_W-1:0] base, input int pause_at);
        int i;
        for (i = 0; i < n; i++) begin
            if (i == pause_at) drain_codes();
            send_pixel(rand_pixel(base), 1'b0, '0);
        end
    endtask

    function automatic void check_field(input string fld, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            if (mismatches < PRINT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
            mismatches++;
        end
    endfunction

    // code word checker
    always @(posedge i_clk) begin : code_check
        lbpv_pkg::t_code_word want;
        if (i_rst_n && code_ch.valid && code_ch.ready) begin
            codes_seen++;
            if (pending_codes.size() == 0) begin
                if (mismatches < PRINT_CAP)
                    $display("%0t: unexpected word, expected none, actual %0d/%0d/%0d/%0b",
                             $time, code_ch.code, code_ch.center_row, code_ch.center_col,
                             code_ch.frame_end);
                mismatches++;
            end else begin
                want = pending_codes.pop_front();
                check_field("code", want.code, code_ch.code);
                check_field("center_row", want.center_row, code_ch.center_row);
                check_field("center_col", want.center_col, code_ch.center_col);
                check_field("frame_end", want.frame_end, code_ch.frame_end);
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        code_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_hold != 0) begin
                code_ch.ready <= 1'b0;
                repeat (stall_hold) @(posedge i_clk);
                stall_hold = 0;
            end
            code_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_ch.valid && pix_ch.ready) || (code_ch.valid && code_ch.ready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                 $time, STALL_LIMIT, pending_codes.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int               ph;
        int               n;
        int               w;
        int               h;
        int               pause_at;
        logic [CFG_W-1:0] fw;
        logic [CFG_W-1:0] fh;
        lbpv_pkg::t_mode  md;
        logic [PIX_W-1:0] base;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 5x5 frame, mode switched between emitting pixels; first code is all-brighter lbp8
        dir_tab = '{
            wr_row(lbpv_pkg::REG_WIDTH, 11'd5), wr_row(lbpv_pkg::REG_HEIGHT, 11'd5),
            wr_row(REG_SPARE, 11'h7FF),
            px_row(8'd255), px_row(8'd255), px_row(8'd255), px_row(8'd17), px_row(8'd128),
            px_row(8'd255), px_row(8'd0), px_row(8'd255), px_row(8'd64), px_row(8'd200),
            px_row(8'd255), px_row(8'd255),
            px_row(8'd255, 1'b1, lbpv_pkg::t_code_word'{8'hFF, 10'd1, 10'd1, 1'b0}),
            wr_row(lbpv_pkg::REG_MODE, CFG_W'(lbpv_pkg::MODE_CSLBP)), px_row(8'd3),
            wr_row(lbpv_pkg::REG_MODE, CFG_W'(lbpv_pkg::MODE_DIAMOND)), px_row(8'd254),
            px_row(8'd90), px_row(8'd1),
            wr_row(lbpv_pkg::REG_MODE, CFG_W'(lbpv_pkg::MODE_SQUARE)), px_row(8'd180),
            wr_row(lbpv_pkg::REG_MODE, CFG_W'(lbpv_pkg::MODE_RING)), px_row(8'd77),
            wr_row(lbpv_pkg::REG_MODE, CFG_W'(lbpv_pkg::MODE_HALF_RING)), px_row(8'd128),
            px_row(8'd40), px_row(8'd222),
            wr_row(lbpv_pkg::REG_MODE, CFG_W'(lbpv_pkg::MODE_THREE_PATCH)), px_row(8'd5),
            px_row(8'd255),
            wr_row(lbpv_pkg::REG_MODE, CFG_W'(lbpv_pkg::MODE_FOUR_PATCH)), px_row(8'd0)
        };
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_WRITE)
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            else
                send_pixel(dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].word);
        end

        // random setups; every fifth one changes only the mode mid-frame
        ph = 0;
        while (pixels_sent < RAND_PIXELS - TALL_PIXELS) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
                default: begin src_idle_pct = 31; snk_stall_pct = 31; end
            endcase
            md       = (ph < 8) ? lbpv_pkg::t_mode'(ph) : lbpv_pkg::t_mode'($urandom_range(7));
            base     = PIX_W'($urandom_range(252));
            pause_at = -1;
            fw       = CFG_W'($urandom_range(3, 12));
            fh       = CFG_W'($urandom_range(3, 10));
            case (ph)
                1: begin fw = 11'd0; fh = 11'd4; end
                2: begin fw = 11'd7; fh = 11'd0; end
                3: begin fw = 11'd2; fh = 11'd6; end
                5: begin
                    fw = 11'd12;
                    fh = 11'd10;
                    md = lbpv_pkg::MODE_LBP8;
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                7: begin fw = 11'd4; fh = 11'd4; end
                default: ;
            endcase
            write_reg(lbpv_pkg::REG_MODE, CFG_W'(md));
            if (ph % 5 == 4) begin
                n = $urandom_range(10, 60);
            end else begin
                write_reg(lbpv_pkg::REG_WIDTH, fw);
                write_reg(lbpv_pkg::REG_HEIGHT, fh);
                w = clamp_dim(fw, MAX_WIDTH);
                h = clamp_dim(fh, MAX_HEIGHT);
                n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
            end
            if (ph == 5) stall_hold = HOLD_CYCLES;
            if (ph == 6) pause_at = n / 2;
            stream_pixels(n, base, pause_at);
            ph++;
        end

        // narrow frame with an oversized height that saturates
        src_idle_pct  = 31;
        snk_stall_pct = 31;
        write_reg(lbpv_pkg::REG_MODE, CFG_W'(lbpv_pkg::MODE_SQUARE));
        write_reg(lbpv_pkg::REG_WIDTH, 11'd3);
        write_reg(lbpv_pkg::REG_HEIGHT, 11'h7FF);
        stream_pixels(TALL_PIXELS, PIX_W'($urandom_range(252)), -1);

        drain_codes();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("Run: %0d pixels over %0d random setups plus a tall narrow frame, all modes.",
                 pixels_sent, ph);
        $display("Checked %0d code words, %0d mismatches.", codes_seen, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
